// ----- hdl/dol_pkg.sv -----
package dol_pkg;

   localparam int unsigned CookieLen = 4;

   localparam logic [7:0] OPT_PAD = 8'h00;
   localparam logic [7:0] OPT_END = 8'hff;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND  = 2'd1;
   localparam logic [1:0] ST_BADCOOKIE = 2'd2;
   localparam logic [1:0] ST_TRUNC     = 2'd3;

   localparam logic KIND_VALUE   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [7:0] TARGET_RESET = 8'd53;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] value_byte;
      logic [7:0] option_length;
      logic [1:0] status;
      logic       run_last;
   } result_type;

   // Up to two results come out of one input byte.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = 8'd99;
         2'd1: b = 8'd130;
         2'd2: b = 8'd83;
         default: b = 8'd99;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/dol_parser.sv -----
module dol_parser
   import dol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output push_type   push
);

   localparam logic [2:0] PH_COOKIE = 3'd0;
   localparam logic [2:0] PH_CODE   = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_MLEN   = 3'd4;
   localparam logic [2:0] PH_VALUE  = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   logic [7:0] target_ff;
   logic [2:0] phase_ff, phase_in;
   logic [1:0] cookie_pos_ff, cookie_pos_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] mlen_ff, mlen_in;
   logic       sent_ff, sent_in;

   always_comb begin
      logic [2:0] ph;
      logic [1:0] pos;
      logic [7:0] rem;
      logic [7:0] ml;
      logic       snt;
      logic       val_emit;
      logic       sum_emit;
      logic [7:0] sum_len;
      logic [1:0] sum_st;
      result_type val_res;
      result_type sum_res;

      ph       = phase_ff;
      pos      = cookie_pos_ff;
      rem      = remaining_ff;
      ml       = mlen_ff;
      snt      = sent_ff;
      val_emit = 1'b0;
      sum_emit = 1'b0;
      sum_len  = 8'd0;
      sum_st   = ST_FOUND;

      unique case (phase_ff)
         PH_COOKIE: begin
            if (data_byte != cookie_byte(cookie_pos_ff)) begin
               sum_emit = 1'b1;
               sum_st   = ST_BADCOOKIE;
            end else begin
               pos = cookie_pos_ff + 2'd1;
               if (cookie_pos_ff == 2'(CookieLen - 1)) begin
                  ph = PH_CODE;
               end
            end
         end
         PH_CODE: begin
            priority if (data_byte == OPT_PAD) begin
               ph = PH_CODE;
            end else if (data_byte == OPT_END) begin
               sum_emit = 1'b1;
               sum_st   = ST_NOTFOUND;
            end else if (data_byte == target_ff) begin
               ph = PH_MLEN;
            end else begin
               ph = PH_LEN;
            end
         end
         PH_LEN: begin
            rem = data_byte;
            ph  = (data_byte == 8'd0) ? PH_CODE : PH_SKIP;
         end
         PH_SKIP: begin
            rem = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               ph = PH_CODE;
            end
         end
         PH_MLEN: begin
            ml  = data_byte;
            rem = data_byte;
            if (data_byte == 8'd0) begin
               sum_emit = 1'b1;
               sum_st   = ST_FOUND;
            end else begin
               ph = PH_VALUE;
            end
         end
         PH_VALUE: begin
            val_emit = 1'b1;
            rem      = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               sum_emit = 1'b1;
               sum_st   = ST_FOUND;
               sum_len  = mlen_ff;
            end
         end
         default: begin
            ph = phase_ff;
         end
      endcase

      if (sum_emit) begin
         snt = 1'b1;
         ph  = PH_DONE;
      end

      // At the end of a packet a summary is owed unless one has gone out.
      if (last_byte) begin
         if (!snt) begin
            sum_emit = 1'b1;
            sum_len  = 8'd0;
            priority if (ph == PH_COOKIE) begin
               sum_st = ST_BADCOOKIE;
            end else if (ph == PH_MLEN) begin
               sum_st = ST_TRUNC;
            end else if (ph == PH_VALUE) begin
               sum_st  = ST_TRUNC;
               sum_len = ml;
            end else begin
               sum_st = ST_NOTFOUND;
            end
         end
         ph  = PH_COOKIE;
         pos = 2'd0;
         rem = 8'd0;
         ml  = 8'd0;
         snt = 1'b0;
      end

      phase_in      = ph;
      cookie_pos_in = pos;
      remaining_in  = rem;
      mlen_in       = ml;
      sent_in       = snt;

      val_res.result_kind   = KIND_VALUE;
      val_res.value_byte    = data_byte;
      val_res.option_length = 8'd0;
      val_res.status        = ST_FOUND;
      val_res.run_last      = !sum_emit;

      sum_res.result_kind   = KIND_SUMMARY;
      sum_res.value_byte    = 8'd0;
      sum_res.option_length = sum_len;
      sum_res.status        = sum_st;
      sum_res.run_last      = 1'b1;

      push.count  = accept ? ({1'b0, val_emit} + {1'b0, sum_emit}) : 2'd0;
      push.first  = val_emit ? val_res : sum_res;
      push.second = sum_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TARGET_RESET;
         phase_ff      <= PH_COOKIE;
         cookie_pos_ff <= 2'd0;
         remaining_ff  <= 8'd0;
         mlen_ff       <= 8'd0;
         sent_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff      <= phase_in;
            cookie_pos_ff <= cookie_pos_in;
            remaining_ff  <= remaining_in;
            mlen_ff       <= mlen_in;
            sent_ff       <= sent_in;
         end
      end
   end

endmodule

// ----- hdl/dol_out_queue.sv -----
module dol_out_queue
   import dol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // Space for two results must be free before the next transaction is taken.
   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/dhcp_option_lookup_top.sv -----
// DHCP option lookup. Options-field bytes, magic cookie first, enter one
// transaction per cycle while req_ready is high, with a last-byte flag; the
// parser walks the records and returns every value byte of the option whose
// code equals csr_wr_data's last written value (53 after reset), then one
// summary per packet with the declared length and a status (found, not
// found, bad cookie, truncated). An input byte gives zero, one or two
// results; the results pass through a four-entry queue, so req_ready stays
// high while at least two entries are free. The sustained rate is one byte
// per cycle while rsp_ready is high and each byte yields at most one result;
// a byte that yields two results needs two transfers on the response port.
module dhcp_option_lookup_top
   import dol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_value_byte,
   output logic [7:0] rsp_option_length,
   output logic [1:0] rsp_status,
   output logic       rsp_run_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   push_type   push;
   result_type head;
   logic       accept;

   assign accept = req_valid && req_ready;

   dol_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push)
   );

   dol_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (req_ready),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (head)
   );

   assign rsp_result_kind   = head.result_kind;
   assign rsp_value_byte    = head.value_byte;
   assign rsp_option_length = head.option_length;
   assign rsp_status        = head.status;
   assign rsp_run_last      = head.run_last;

endmodule
